// ----- hdl/wapava_pkg.sv -----
`timescale 1ns / 1ps
package wapava_pkg;
  localparam int unsigned MaxPointsDef     = 64;
  localparam int unsigned WeightBitsDef    = 16;
  localparam int unsigned ValueFracBitsDef = 16;

  // Fixed field widths of the stream payload.
  localparam int unsigned ValueW  = 17;
  localparam int unsigned InWeightW = 16;
  localparam int unsigned IdxW    = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;      // write the accepted sample on top of the stack
    logic drop;      // sample dropped, mark overflow
    logic cmp_load;  // load top two entries for compare
    logic div_start; // start a merge division
    logic merge_wr;  // write merge result, pop
    logic out_load;  // read entry for output
    logic out_fire;  // present the loaded entry
    logic clear;     // end of run
  } wapava_cmd_t;

  typedef struct packed {
    logic can_push;  // room for the sample
    logic depth_ge2; // at least two entries
    logic violate;   // lower mean not strictly greater
    logic div_done;
    logic out_empty; // output register free
    logic out_more;  // more entries left to emit
    logic stack_empty;
  } wapava_sts_t;
endpackage

// ----- hdl/wapava_div.sv -----
`timescale 1ns / 1ps
module wapava_div import wapava_pkg::*; #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = '0;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;
endmodule

// ----- hdl/wapava_dp.sv -----
`timescale 1ns / 1ps
module wapava_dp import wapava_pkg::*; #(
  parameter int unsigned MaxPoints     = MaxPointsDef,
  parameter int unsigned WeightBits    = WeightBitsDef,
  parameter int unsigned ValueFracBits = ValueFracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wapava_cmd_t          cmd_i,
  output wapava_sts_t          sts_o,
  input  logic [ValueW-1:0]    sample_value_i,
  input  logic [InWeightW-1:0] sample_weight_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [IdxW-1:0]      block_first_o,
  output logic [IdxW-1:0]      block_last_o,
  output logic [ValueW-1:0]    fitted_value_o,
  output logic                 final_block_o,
  output logic                 overflow_o
);
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned MeanW = ValueFracBits + 1;
  localparam int unsigned SumW  = WeightBits + CntW;
  localparam int unsigned NumW  = SumW + MeanW;
  localparam logic [MeanW-1:0] One = MeanW'(1) << ValueFracBits;

  logic [MeanW-1:0] mean_mem [MaxPoints];
  logic [SumW-1:0]  wt_mem   [MaxPoints];
  logic [AddrW-1:0] end_mem  [MaxPoints];

  logic [CntW-1:0]  depth_q, count_q, rd_idx_q;
  logic             ovf_q;
  logic [MeanW-1:0] m_lo_q, m_hi_q;
  logic [SumW-1:0]  w_lo_q, w_hi_q;
  logic [AddrW-1:0] e_hi_q;
  logic [NumW-1:0]  num_q;
  logic [SumW-1:0]  wsum_q;
  logic [NumW-1:0]  quo;
  logic             div_done;
  logic             div_go_q;
  logic [1:0]       mul_ph_q;
  logic [NumW-1:0]  prod_lo, prod_hi;

  logic [MeanW-1:0] val_sat;
  logic [WeightBits-1:0] w_mask;
  logic [SumW-1:0]  w_in;
  logic [AddrW-1:0] top_a, lo_a;

  // Output register
  logic             ov_q;
  logic [IdxW-1:0]  of_q, ol_q;
  logic [ValueW-1:0] om_q;
  logic             ofin_q, oovf_q;
  logic [AddrW-1:0] next_first_q;
  logic [MeanW-1:0] rd_m_q;
  logic [AddrW-1:0] rd_e_q;

  always_comb begin
    val_sat = (ValueW > MeanW && |(sample_value_i >> MeanW)) ? One :
              ((MeanW'(sample_value_i) > One) ? One : MeanW'(sample_value_i));
    if (ValueW > MeanW && |(sample_value_i >> MeanW)) val_sat = One;
    w_mask = WeightBits'(sample_weight_i);
    w_in   = (w_mask == '0) ? SumW'(1) : SumW'(w_mask);
    top_a  = AddrW'(depth_q - 1'b1);
    lo_a   = AddrW'(depth_q - 2'd2);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mean_mem[AddrW'(depth_q)] <= val_sat;
      wt_mem[AddrW'(depth_q)]   <= w_in;
      end_mem[AddrW'(depth_q)]  <= AddrW'(count_q);
    end else if (cmd_i.merge_wr) begin
      mean_mem[lo_a] <= MeanW'(quo);
      wt_mem[lo_a]   <= wsum_q;
      end_mem[lo_a]  <= e_hi_q;
    end
    if (cmd_i.cmp_load) begin
      m_lo_q <= mean_mem[lo_a];
      m_hi_q <= mean_mem[top_a];
      w_lo_q <= wt_mem[lo_a];
      w_hi_q <= wt_mem[top_a];
      e_hi_q <= end_mem[top_a];
    end
    if (cmd_i.out_load) begin
      rd_m_q <= mean_mem[AddrW'(rd_idx_q)];
      rd_e_q <= end_mem[AddrW'(rd_idx_q)];
    end
  end

  // Products are formed at the full numerator width.
  always_comb begin
    prod_lo = w_lo_q * m_lo_q;
    prod_hi = w_hi_q * m_hi_q;
  end

  // Two products, one multiplier each, summed in num_q in turn.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= prod_lo;
      wsum_q <= w_lo_q + w_hi_q;
    end else if (mul_ph_q == 2'd1) begin
      num_q <= num_q + prod_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ph_q <= '0;
      div_go_q <= 1'b0;
    end else begin
      mul_ph_q <= cmd_i.div_start ? 2'd1 : 2'd0;
      div_go_q <= (mul_ph_q == 2'd1);
    end
  end

  wapava_div #(.NumW(NumW), .DenW(SumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num_q),
    .den_i   (wsum_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      rd_idx_q     <= '0;
      ov_q         <= 1'b0;
      next_first_q <= '0;
    end else begin
      if (cmd_i.out_fire) begin
        ov_q         <= 1'b1;
        next_first_q <= rd_e_q + 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.push) begin
        depth_q <= depth_q + 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.drop) ovf_q <= 1'b1;
      if (cmd_i.merge_wr) depth_q <= depth_q - 1'b1;
      if (cmd_i.out_load) rd_idx_q <= rd_idx_q + 1'b1;
      if (cmd_i.clear) begin
        depth_q      <= '0;
        count_q      <= '0;
        ovf_q        <= 1'b0;
        rd_idx_q     <= '0;
        next_first_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_fire) begin
      of_q   <= IdxW'(next_first_q);
      ol_q   <= IdxW'(rd_e_q);
      om_q   <= ValueW'(rd_m_q);
      ofin_q <= (rd_idx_q == depth_q);
      oovf_q <= ovf_q;
    end
  end

  assign sts_o.can_push    = (count_q < CntW'(MaxPoints)) && (depth_q < CntW'(MaxPoints));
  assign sts_o.depth_ge2   = (depth_q >= CntW'(2));
  assign sts_o.violate     = !(m_lo_q > m_hi_q);
  assign sts_o.div_done    = div_done;
  assign sts_o.out_empty   = !ov_q || out_ready_i;
  assign sts_o.out_more    = (rd_idx_q < depth_q);
  assign sts_o.stack_empty = (depth_q == '0);

  assign out_valid_o    = ov_q;
  assign block_first_o  = of_q;
  assign block_last_o   = ol_q;
  assign fitted_value_o = om_q;
  assign final_block_o  = ofin_q;
  assign overflow_o     = oovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= count_q) else $error("stack deeper than sample count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_wr |-> depth_q >= CntW'(2)) else $error("merge with short stack");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_fire |-> !ov_q || out_ready_i) else $error("output overwritten");
endmodule

// ----- hdl/wapava_ctrl.sv -----
`timescale 1ns / 1ps
module wapava_ctrl import wapava_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        last_i,
  output logic        in_ready_o,
  input  wapava_sts_t sts_i,
  output wapava_cmd_t cmd_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SCmp  = 3'd1;
  localparam logic [2:0] SChk  = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SOutR = 3'd4;
  localparam logic [2:0] SOutW = 3'd5;

  logic [2:0] state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d = last_i;
          if (sts_i.can_push) begin
            cmd_o.push = 1'b1;
            state_d    = SCmp;
          end else begin
            cmd_o.drop = 1'b1;
            state_d    = last_i ? SOutR : SIdle;
          end
        end
      end
      SCmp: begin
        if (sts_i.depth_ge2) begin
          cmd_o.cmp_load = 1'b1;
          state_d        = SChk;
        end else begin
          state_d = last_q ? SOutR : SIdle;
        end
      end
      SChk: begin
        if (sts_i.violate) begin
          cmd_o.div_start = 1'b1;
          state_d         = SDiv;
        end else begin
          state_d = last_q ? SOutR : SIdle;
        end
      end
      SDiv: begin
        if (sts_i.div_done) begin
          cmd_o.merge_wr = 1'b1;
          state_d        = SCmp;
        end
      end
      SOutR: begin
        if (sts_i.out_more) begin
          cmd_o.out_load = 1'b1;
          state_d        = SOutW;
        end else begin
          cmd_o.clear = 1'b1;
          state_d     = SIdle;
        end
      end
      SOutW: begin
        if (sts_i.out_empty) begin
          cmd_o.out_fire = 1'b1;
          state_d        = SOutR;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == SIdle) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == SDiv) else $error("division not tracked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push, cmd_o.merge_wr, cmd_o.clear})) else $error("stack command clash");
endmodule

// ----- hdl/weighted_antitonic_pava_core.sv -----
`timescale 1ns / 1ps
// Weighted antitonic regression by pool-adjacent-violators. Each input beat pushes one
// sample; while the entry below is not strictly greater, the two merge into their
// truncated weighted mean. Each merge runs on the shared bit-serial divider. A beat
// with tlast then emits every block, accepting no input meanwhile, and clears the
// stack. Samples beyond MaxPoints are dropped and flagged in every output beat of
// the run.
module weighted_antitonic_pava_core import wapava_pkg::*; #(
  parameter int unsigned MaxPoints     = MaxPointsDef,
  parameter int unsigned WeightBits    = WeightBitsDef,
  parameter int unsigned ValueFracBits = ValueFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // sample_value[16:0], sample_weight[32:17], zero pad
  input  logic        s_axis_tlast,  // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // block_first[5:0], block_last[11:6], fitted_value[28:12]
  output logic        m_axis_tlast,  // final_block
  output logic        m_axis_tuser   // overflow
);
  wapava_cmd_t cmd;
  wapava_sts_t sts;
  logic [IdxW-1:0]   bf, bl;
  logic [ValueW-1:0] fv;

  wapava_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .last_i     (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wapava_dp #(
    .MaxPoints(MaxPoints), .WeightBits(WeightBits), .ValueFracBits(ValueFracBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_value_i  (s_axis_tdata[16:0]),
    .sample_weight_i (s_axis_tdata[32:17]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .block_first_o   (bf),
    .block_last_o    (bl),
    .fitted_value_o  (fv),
    .final_block_o   (m_axis_tlast),
    .overflow_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, fv, bl, bf};
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench import wapava_pkg::*; ();

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned OneQ = 1 << ValueFracBitsDef;

  typedef struct packed {
    logic [IdxW-1:0]   first_idx;
    logic [IdxW-1:0]   last_idx;
    logic [ValueW-1:0] fitted;
    logic              final_blk;
    logic              ovf;
  } block_fit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  weighted_antitonic_pava_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow copy of the pooling stack.
  logic [63:0] pool_mean [MaxPointsDef];
  logic [63:0] pool_weight [MaxPointsDef];
  int unsigned pool_end [MaxPointsDef];
  int unsigned pool_depth;
  int unsigned run_count;
  bit          run_dropped;

  block_fit_t  fit_queue [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned hold_off;
  bit          no_idle;
  int unsigned samples_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Receiver: random ready, with a long hold-off whenever hold_off is loaded.
  always @(posedge clk_i or negedge rst_ni) begin
    block_fit_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (fit_queue.size() == 0) begin
          report_mismatch("unexpected output beat", m_axis_tdata, '0);
        end else begin
          want = fit_queue.pop_front();
          if (m_axis_tdata[5:0] !== want.first_idx)
            report_mismatch("block_first", m_axis_tdata[5:0], want.first_idx);
          if (m_axis_tdata[11:6] !== want.last_idx)
            report_mismatch("block_last", m_axis_tdata[11:6], want.last_idx);
          if (m_axis_tdata[28:12] !== want.fitted)
            report_mismatch("fitted_value", m_axis_tdata[28:12], want.fitted);
          if (m_axis_tlast !== want.final_blk)
            report_mismatch("final_block", m_axis_tlast, want.final_blk);
          if (m_axis_tuser !== want.ovf)
            report_mismatch("overflow", m_axis_tuser, want.ovf);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Pushes or drops one accepted sample and pools; on the last sample lists the blocks.
  task automatic pool_sample(input logic [16:0] value, input logic [15:0] weight,
                             input bit last);
    logic [63:0] v;
    logic [63:0] w;
    logic [63:0] wsum;
    int unsigned lo;
    int unsigned first;
    block_fit_t fit;
    v = (value > OneQ) ? 64'(OneQ) : 64'(value);
    w = (weight == 0) ? 64'd1 : 64'(weight);
    if (run_count < MaxPointsDef && pool_depth < MaxPointsDef) begin
      pool_mean[pool_depth] = v;
      pool_weight[pool_depth] = w;
      pool_end[pool_depth] = run_count;
      pool_depth++;
      run_count++;
      while (pool_depth >= 2) begin
        lo = pool_depth - 2;
        if (pool_mean[lo] > pool_mean[lo + 1]) break;
        wsum = pool_weight[lo] + pool_weight[lo + 1];
        pool_mean[lo] = (pool_weight[lo] * pool_mean[lo] +
                         pool_weight[lo + 1] * pool_mean[lo + 1]) / wsum;
        pool_weight[lo] = wsum;
        pool_end[lo] = pool_end[lo + 1];
        pool_depth--;
      end
    end else begin
      run_dropped = 1'b1;
    end
    if (last) begin
      first = 0;
      for (int unsigned k = 0; k < pool_depth; k++) begin
        fit.first_idx = first[IdxW-1:0];
        fit.last_idx = pool_end[k][IdxW-1:0];
        fit.fitted = pool_mean[k][ValueW-1:0];
        fit.final_blk = (k + 1 == pool_depth);
        fit.ovf = run_dropped;
        fit_queue = {fit_queue, fit};
        first = pool_end[k] + 1;
      end
      pool_depth = 0;
      run_count = 0;
      run_dropped = 1'b0;
    end
  endtask

  task automatic send_sample(input logic [16:0] value, input logic [15:0] weight,
                             input bit last);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) gap = 0;
    else if (r < 94) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, weight, value};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pool_sample(value, weight, last);
    samples_sent++;
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    pause_sender();
    while (fit_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    // Rising values pool into one block; weight zero counts as one.
    send_sample(17'd0, 16'd0, 1'b0);
    send_sample(17'd65536, 16'd65535, 1'b0);
    send_sample(17'h1FFFF, 16'd1, 1'b1);
    // Falling values with one rise: the rise merges, the rest stay apart.
    send_sample(17'h1FFFF, 16'hFFFF, 1'b0);
    send_sample(17'h0AAAA, 16'h5555, 1'b0);
    send_sample(17'h15555, 16'hAAAA, 1'b0);
    send_sample(17'd1, 16'd2, 1'b0);
    send_sample(17'd0, 16'd7, 1'b1);
    // Equal values must merge too.
    send_sample(17'd1000, 16'd3, 1'b0);
    send_sample(17'd1000, 16'd5, 1'b1);
    // Single sample run.
    send_sample(17'd40000, 16'd9, 1'b1);
    wait_drained();
  endtask

  task automatic test_capacity();
    // More samples than the stack holds; the dropped last one still closes the run.
    for (int i = 0; i < 70; i++)
      send_sample(17'(65536 - i * 900), 16'($urandom_range(1, 100)), i == 69);
    for (int i = 0; i < MaxPointsDef; i++)
      send_sample(17'($urandom_range(0, 65536)), 16'($urandom), i == MaxPointsDef - 1);
    wait_drained();
  endtask

  task automatic random_run(input int unsigned len);
    int unsigned level;
    int unsigned v;
    level = $urandom_range(30000, 65536);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: v = $urandom_range(0, 131071);
        1, 2: v = level + $urandom_range(0, 4000);
        default: v = (level > 3000) ? level - $urandom_range(0, 3000) : level;
      endcase
      level = (v > 65536) ? 65536 : v;
      send_sample(17'(v), 16'($urandom), i == len - 1);
    end
  endtask

  task automatic test_random_runs();
    while (samples_sent < 330) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 14) == 0) random_run($urandom_range(60, 70));
      else random_run($urandom_range(1, 16));
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    // The receiver stalls while full runs keep coming, so the core must stall its input.
    hold_off = 3000;
    random_run(MaxPointsDef);
    random_run(MaxPointsDef);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    error_count = 0;
    cycle_count = 0;
    hold_off = 0;
    no_idle = 1'b0;
    samples_sent = 0;
    pool_depth = 0;
    run_count = 0;
    run_dropped = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_capacity();
    test_random_runs();
    test_backpressure();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/wapava_pkg.sv
hdl/wapava_div.sv
hdl/wapava_dp.sv
hdl/wapava_ctrl.sv
hdl/weighted_antitonic_pava_core.sv
dv/testbench.sv
